/* rtl/ars_pkg.sv */
// ars_pkg: shared types and constants of the resample and mix unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package ars_pkg;

    localparam int ACC_W       = 18;
    localparam int RATE_W      = 17;
    localparam int SRC_W       = 16;
    localparam int CNT_W       = 13;
    localparam int SMP_W       = 8;
    localparam int BURST_W     = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 17;

    // frame_samples is 13 bits, so it never exceeds this cap
    localparam int MAX_FRAME_SAMPLES = 8192;

    localparam logic [ACC_W-1:0]   ACC_MAX   = {ACC_W{1'b1}};
    localparam logic [BURST_W-1:0] BURST_END = {BURST_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] REG_OUT_RATE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_RATE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_SAMPLES = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIX_MODE      = 2'd3;

    localparam logic [RATE_W-1:0] RST_OUT_RATE      = 17'd48000;
    localparam logic [SRC_W-1:0]  RST_SOURCE_RATE   = 16'd31440;
    localparam logic [CNT_W-1:0]  RST_FRAME_SAMPLES = 13'd800;

    typedef struct packed {
        logic [RATE_W-1:0] out_rate;
        logic [SRC_W-1:0]  source_rate;
        logic [CNT_W-1:0]  frame_samples;
        logic              mix_mode;
    } t_cfg;

    typedef struct packed {
        logic             frame_start;
        logic [SMP_W-1:0] sample;
    } t_item;

endpackage

/* rtl/ars_in_if.sv */
// ars_in_if: input channel, one source-rate word per handshake.
// Depends on ars_pkg for field widths.
`timescale 1ns / 1ps
interface ars_in_if;
    import ars_pkg::*;
    logic             valid;
    logic             ready;
    logic             frame_start;
    logic [SMP_W-1:0] primary_sample;
    logic [SMP_W-1:0] secondary_sample;

    modport source(output valid, frame_start, primary_sample, secondary_sample,
                   input ready);
    modport sink(input valid, frame_start, primary_sample, secondary_sample,
                 output ready);
endinterface

/* rtl/ars_out_if.sv */
// ars_out_if: output channel, one output-rate word per handshake.
// Depends on ars_pkg for field widths.
`timescale 1ns / 1ps
interface ars_out_if;
    import ars_pkg::*;
    logic             valid;
    logic             ready;
    logic [SMP_W-1:0] out_sample;
    logic             run_last;
    logic             frame_last;

    modport source(output valid, out_sample, run_last, frame_last, input ready);
    modport sink(input valid, out_sample, run_last, frame_last, output ready);
endinterface

/* rtl/ars_cfg_if.sv */
// ars_cfg_if: register write channel, index and data per word.
// Depends on ars_pkg for field widths.
`timescale 1ns / 1ps
interface ars_cfg_if;
    import ars_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

/* rtl/audio_resample_and_mix_unit.sv */
// Nearest-neighbor sample rate converter and two-source mixer. Each input
// word carries one source-rate sample pair; each output word is one
// output-rate sample. The back end loads the phase accumulator per input
// word in IDLE, then emits its output words (up to eight) in EMIT through
// its single accumulator subtractor; a word with no output still visits
// both states. A two-entry queue lets the front end take input
// words while the back end works or the output stalls. Register writes are
// always accepted in the cycle they are offered.
// Depends on ars_pkg, the ars_*_if interfaces, ars_front, ars_queue, ars_back.
`timescale 1ns / 1ps
module audio_resample_and_mix_unit
    import ars_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    ars_cfg_if.sink   i_cfg,
    ars_in_if.sink    i_in,
    ars_out_if.source o_out
);
    t_cfg  r_cfg;
    logic  w_full, w_empty, w_push, w_pop;
    t_item w_push_item, w_pop_item;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.out_rate      <= RST_OUT_RATE;
            r_cfg.source_rate   <= RST_SOURCE_RATE;
            r_cfg.frame_samples <= RST_FRAME_SAMPLES;
            r_cfg.mix_mode      <= 1'b0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_OUT_RATE:      r_cfg.out_rate      <= i_cfg.data[RATE_W-1:0];
                REG_SOURCE_RATE:   r_cfg.source_rate   <= i_cfg.data[SRC_W-1:0];
                REG_FRAME_SAMPLES: r_cfg.frame_samples <= i_cfg.data[CNT_W-1:0];
                REG_MIX_MODE:      r_cfg.mix_mode      <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    ars_front u_front (
        .i_in   (i_in),
        .i_cfg  (r_cfg),
        .i_full (w_full),
        .o_push (w_push),
        .o_item (w_push_item)
    );

    ars_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_item  (w_pop_item)
    );

    ars_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_empty (w_empty),
        .i_item  (w_pop_item),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );
endmodule

/* rtl/ars_front.sv */
// ars_front: accepts input words, forms the held sample (mix or 3/4 scale).
// Depends on ars_pkg and ars_in_if; feeds ars_queue.
`timescale 1ns / 1ps
module ars_front
    import ars_pkg::*;
(
    ars_in_if.sink  i_in,
    input  t_cfg    i_cfg,
    input  logic    i_full,
    output logic    o_push,
    output t_item   o_item
);
    logic [SMP_W:0]   w_sum;
    logic [SMP_W+1:0] w_triple;

    assign w_sum    = {1'b0, i_in.primary_sample} + {1'b0, i_in.secondary_sample};
    assign w_triple = {1'b0, i_in.primary_sample, 1'b0} + {2'b00, i_in.primary_sample};

    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;

    always_comb begin
        o_item.frame_start = i_in.frame_start;
        if (i_cfg.mix_mode) begin
            o_item.sample = w_sum[SMP_W:1];
        end else begin
            o_item.sample = w_triple[SMP_W+1:2];
        end
    end
endmodule

/* rtl/ars_queue.sv */
// ars_queue: two-entry queue of classified words between front and back.
// Depends on ars_pkg.
`timescale 1ns / 1ps
module ars_queue
    import ars_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_empty,
    output t_item o_item
);
    t_item       r_mem [2];
    logic        r_wp;
    logic        r_rp;
    logic [1:0]  r_cnt;
    logic [1:0]  n_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_item  = r_mem[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end
endmodule

/* rtl/ars_back.sv */
// ars_back: phase accumulator, frame count and output register.
// Depends on ars_pkg and ars_out_if; drains ars_queue.
`timescale 1ns / 1ps
module ars_back
    import ars_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_empty,
    input  t_item    i_item,
    output logic     o_pop,
    ars_out_if.source o_out
);
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic               r_state, n_state;
    logic [ACC_W-1:0]   r_acc, n_acc;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [BURST_W-1:0] r_burst, n_burst;
    logic [SMP_W-1:0]   r_sample;
    logic               r_out_valid, n_out_valid;
    logic [SMP_W-1:0]   r_out_sample;
    logic               r_out_run_last, r_out_frame_last;

    logic [ACC_W:0]     w_sum;
    logic [ACC_W-1:0]   w_acc_add;
    logic [ACC_W-1:0]   w_src;
    logic [ACC_W-1:0]   w_acc_sub;
    logic [CNT_W-1:0]   w_cnt_inc;
    logic               w_can_emit, w_more, w_slot_free, w_emit;

    assign w_sum       = {1'b0, r_acc} + {2'b00, i_cfg.out_rate};
    assign w_acc_add   = w_sum[ACC_W] ? ACC_MAX : w_sum[ACC_W-1:0];
    assign w_src       = {2'b00, i_cfg.source_rate};
    assign w_acc_sub   = r_acc - w_src;
    assign w_cnt_inc   = r_count + {{(CNT_W-1){1'b0}}, 1'b1};
    assign w_can_emit  = (r_count < i_cfg.frame_samples) && (r_acc >= w_src);
    assign w_more      = (r_burst != BURST_END) && (w_cnt_inc < i_cfg.frame_samples)
                         && (w_acc_sub >= w_src);
    assign w_slot_free = !r_out_valid || o_out.ready;
    assign w_emit      = (r_state == ST_EMIT) && w_slot_free && w_can_emit;
    assign o_pop       = (r_state == ST_IDLE) && !i_empty;

    assign o_out.valid      = r_out_valid;
    assign o_out.out_sample = r_out_sample;
    assign o_out.run_last   = r_out_run_last;
    assign o_out.frame_last = r_out_frame_last;

    always_comb begin
        n_state     = r_state;
        n_acc       = r_acc;
        n_count     = r_count;
        n_burst     = r_burst;
        n_out_valid = r_out_valid && !o_out.ready;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    n_burst = '0;
                    n_state = ST_EMIT;
                    if (i_item.frame_start) begin
                        n_acc   = {1'b0, i_cfg.out_rate};
                        n_count = '0;
                    end else begin
                        n_acc = w_acc_add;
                    end
                end
            end
            ST_EMIT: begin
                if (w_slot_free) begin
                    if (w_can_emit) begin
                        n_acc       = w_acc_sub;
                        n_count     = w_cnt_inc;
                        n_burst     = r_burst + {{(BURST_W-1){1'b0}}, 1'b1};
                        n_out_valid = 1'b1;
                        if (!w_more) begin
                            n_state = ST_IDLE;
                        end
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_acc       <= '0;
            r_count     <= '0;
            r_burst     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_acc       <= n_acc;
            r_count     <= n_count;
            r_burst     <= n_burst;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_sample <= i_item.sample;
        end
        if (w_emit) begin
            r_out_sample     <= r_sample;
            r_out_run_last   <= !w_more;
            r_out_frame_last <= (w_cnt_inc == i_cfg.frame_samples);
        end
    end

`ifndef SYNTH
    a_count_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |-> (r_count < i_cfg.frame_samples))
        else $error("emit past frame end");
    a_burst_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && r_burst == BURST_END) |=> o_out.run_last)
        else $error("burst of more than eight words");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |-> !w_emit)
        else $error("output register overwritten");
    a_pop_in_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state == ST_EMIT))
        else $error("pop without entering emit");
`endif
endmodule
